// ----- design/bcc_pkg.sv -----
// bcc_pkg: shared types and constants for the button click classifier.
// Used by bcc_core and button_click_classifier; no dependencies.
package bcc_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned EventW = 3;
  localparam int unsigned TallyW = 2;
  localparam int unsigned CfgIdxW = 8;

  // event codes
  localparam logic [EventW-1:0] EV_NONE      = 3'd0;
  localparam logic [EventW-1:0] EV_SHORT     = 3'd1;
  localparam logic [EventW-1:0] EV_DOUBLE    = 3'd2;
  localparam logic [EventW-1:0] EV_TRIPLE    = 3'd3;
  localparam logic [EventW-1:0] EV_LONG      = 3'd4;
  localparam logic [EventW-1:0] EV_VERY_LONG = 3'd5;

  localparam logic [TallyW-1:0] TALLY_MAX = 2'd3;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_DEBOUNCE  = 8'd0;
  localparam logic [CfgIdxW-1:0] REG_LONG      = 8'd1;
  localparam logic [CfgIdxW-1:0] REG_VERY_LONG = 8'd2;
  localparam logic [CfgIdxW-1:0] REG_WINDOW    = 8'd3;

  localparam logic [CfgW-1:0] DEBOUNCE_RST  = 16'd50;
  localparam logic [CfgW-1:0] LONG_RST      = 16'd1000;
  localparam logic [CfgW-1:0] VERY_LONG_RST = 16'd3000;
  localparam logic [CfgW-1:0] WINDOW_RST    = 16'd300;

  typedef struct packed {
    logic [CfgW-1:0] debounce_ms;
    logic [CfgW-1:0] long_press_ms;
    logic [CfgW-1:0] very_long_press_ms;
    logic [CfgW-1:0] multi_click_window_ms;
  } bcc_cfg_t;

  typedef struct packed {
    logic              pressed;
    logic [TimeW-1:0]  debounce_stamp;
    logic [TimeW-1:0]  press_stamp;
    logic              long_done;
    logic              very_long_done;
    logic [TallyW-1:0] click_tally;
    logic [TimeW-1:0]  release_stamp;
    logic              awaiting_more;
  } bcc_state_t;

endpackage

// ----- design/bcc_core.sv -----
// bcc_core: next-state and event logic for one poll of the click classifier.
// Depends on bcc_pkg. Purely combinational; state lives in the top level.
module bcc_core
  import bcc_pkg::*;
(
  input  bcc_cfg_t          cfg,
  input  bcc_state_t        st,
  input  logic [TimeW-1:0]  now_ms,
  input  logic              raw_pin,
  input  logic              edge_flag,
  output bcc_state_t        st_nxt,
  output logic [EventW-1:0] event_code
);

  logic [TimeW-1:0] db_stamp;
  logic [TimeW-1:0] quiet_time;
  logic [TimeW-1:0] held_time;
  logic [TimeW-1:0] gap_time;
  logic             adopt;
  logic             just_pressed;
  logic             just_counted;
  logic             ge_long;
  logic             ge_very_long;
  logic             ge_window;

  assign db_stamp   = edge_flag ? now_ms : st.debounce_stamp;
  assign quiet_time = now_ms - db_stamp;
  assign held_time  = now_ms - st.press_stamp;
  assign gap_time   = now_ms - st.release_stamp;

  assign adopt = (quiet_time >= {16'd0, cfg.debounce_ms}) && (raw_pin != st.pressed);
  assign just_pressed = adopt && raw_pin;
  // a release counted this poll restarts the window at zero elapsed time
  assign just_counted = adopt && !raw_pin && !st.long_done && !st.very_long_done;

  // elapsed time is zero on the poll that sets the stamp
  assign ge_long      = just_pressed ? (cfg.long_press_ms == '0)
                                     : (held_time >= {16'd0, cfg.long_press_ms});
  assign ge_very_long = just_pressed ? (cfg.very_long_press_ms == '0)
                                     : (held_time >= {16'd0, cfg.very_long_press_ms});
  assign ge_window    = just_counted ? (cfg.multi_click_window_ms == '0)
                                     : (gap_time >= {16'd0, cfg.multi_click_window_ms});

  always_comb begin
    st_nxt = st;
    st_nxt.debounce_stamp = db_stamp;
    event_code = EV_NONE;

    if (adopt) begin
      st_nxt.pressed = raw_pin;
      if (raw_pin) begin
        st_nxt.press_stamp    = now_ms;
        st_nxt.long_done      = 1'b0;
        st_nxt.very_long_done = 1'b0;
      end else if (just_counted) begin
        if (st.click_tally != TALLY_MAX) begin
          st_nxt.click_tally = st.click_tally + 2'd1;
        end
        st_nxt.release_stamp = now_ms;
        st_nxt.awaiting_more = 1'b1;
      end else begin
        st_nxt.click_tally   = '0;
        st_nxt.awaiting_more = 1'b0;
      end
    end

    if (st_nxt.pressed) begin
      if (!st_nxt.very_long_done && ge_very_long) begin
        event_code = EV_VERY_LONG;
        st_nxt.very_long_done = 1'b1;
        st_nxt.long_done      = 1'b1;
      end else if (!st_nxt.long_done && ge_long) begin
        event_code = EV_LONG;
        st_nxt.long_done = 1'b1;
      end
    end else if (st_nxt.awaiting_more) begin
      if (ge_window || st_nxt.click_tally == TALLY_MAX) begin
        case (st_nxt.click_tally)
          2'd1:      event_code = EV_SHORT;
          2'd2:      event_code = EV_DOUBLE;
          TALLY_MAX: event_code = EV_TRIPLE;
          default:   event_code = EV_NONE;
        endcase
        st_nxt.click_tally   = '0;
        st_nxt.awaiting_more = 1'b0;
      end
    end
  end

endmodule

// ----- design/button_click_classifier.sv -----
// button_click_classifier: top level; input register, state, result register.
// Depends on bcc_pkg and bcc_core.
//
//  channel | ports                                      | direction
//  --------+--------------------------------------------+----------
//  in      | in_valid in_ready in_now_ms in_raw_pin      | sink
//          | in_edge_flag                               |
//  out     | out_valid out_ready out_event_code         | source
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data     | sink
//
// An input transaction waits in the input register, then passes through
// bcc_core into the result register. One poll per cycle is sustained while
// out_ready stays high; the state update of a poll is done in the same cycle
// it leaves the input register, so polls may follow back to back.
// A stalled output holds both stages; the input register still takes a
// transaction while empty. Reset (rst_n low, synchronous) restores the config,
// state and valid flags to their defaults. cfg_ready is always high.
module button_click_classifier
  import bcc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [TimeW-1:0]    in_now_ms,
  input  logic                in_raw_pin,
  input  logic                in_edge_flag,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [EventW-1:0]   out_event_code,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgW-1:0]     cfg_data
);

  bcc_cfg_t          cfg_r;
  bcc_state_t        st_r;
  bcc_state_t        st_nxt;
  logic              in_v_r;
  logic [TimeW-1:0]  now_r;
  logic              pin_r;
  logic              edge_r;
  logic              out_v_r;
  logic [EventW-1:0] ev_r;
  logic [EventW-1:0] ev_nxt;
  logic              advance;

  assign advance   = in_v_r && (!out_v_r || out_ready);
  assign in_ready  = !in_v_r || advance;
  assign cfg_ready = 1'b1;
  assign out_valid = out_v_r;
  assign out_event_code = ev_r;

  bcc_core u_core (
    .cfg        (cfg_r),
    .st         (st_r),
    .now_ms     (now_r),
    .raw_pin    (pin_r),
    .edge_flag  (edge_r),
    .st_nxt     (st_nxt),
    .event_code (ev_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ms           <= DEBOUNCE_RST;
      cfg_r.long_press_ms         <= LONG_RST;
      cfg_r.very_long_press_ms    <= VERY_LONG_RST;
      cfg_r.multi_click_window_ms <= WINDOW_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DEBOUNCE:  cfg_r.debounce_ms           <= cfg_data;
        REG_LONG:      cfg_r.long_press_ms         <= cfg_data;
        REG_VERY_LONG: cfg_r.very_long_press_ms    <= cfg_data;
        REG_WINDOW:    cfg_r.multi_click_window_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      now_r  <= in_now_ms;
      pin_r  <= in_raw_pin;
      edge_r <= in_edge_flag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= '0;
      out_v_r <= 1'b0;
    end else begin
      if (advance) begin
        st_r    <= st_nxt;
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      ev_r <= ev_nxt;
    end
  end

  // a full tally is always reported in the poll that reaches it
  a_tally_never_full: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.click_tally != TALLY_MAX)
    else $error("click tally held at its limit");

  a_very_long_implies_long: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.very_long_done |-> st_r.long_done)
    else $error("very long done without long done");

  a_waiting_has_clicks: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.awaiting_more |-> (st_r.click_tally != '0))
    else $error("awaiting more clicks with empty tally");

  a_event_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (ev_r <= EV_VERY_LONG))
    else $error("event code out of range");

  a_hold_event_while_pressed: assert property (@(posedge clk) disable iff (!rst_n)
    advance && (ev_nxt == EV_LONG || ev_nxt == EV_VERY_LONG) |=> st_r.pressed)
    else $error("hold event without pressed state");

endmodule

// ----- bench/tb_button_click_classifier.sv -----
`timescale 1ns / 1ps
// Testbench for button_click_classifier: a scoreboard class predicts the event of every poll,
// and tasks drive gestures, bounces and noise over several register settings.
// Depends on bcc_pkg and the button_click_classifier RTL.

import bcc_pkg::*;

typedef struct {
  logic [EventW-1:0] code;
  logic [TimeW-1:0]  now;
  int unsigned       seq;
} click_expect_t;

class click_scoreboard;
  bcc_cfg_t      cfg;
  bcc_state_t    st;
  click_expect_t expected_events[$];
  int unsigned   polls;
  int unsigned   checked;
  int unsigned   errors;
  int unsigned   hits[6];

  function new();
    cfg = '{DEBOUNCE_RST, LONG_RST, VERY_LONG_RST, WINDOW_RST};
    st = '0;
  endfunction

  function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
    case (idx)
      REG_DEBOUNCE:  cfg.debounce_ms = data;
      REG_LONG:      cfg.long_press_ms = data;
      REG_VERY_LONG: cfg.very_long_press_ms = data;
      REG_WINDOW:    cfg.multi_click_window_ms = data;
      default: ;
    endcase
  endfunction

  // Debounce/adoption, then hold thresholds, then the multi-click report.
  function void note_poll(logic [TimeW-1:0] now, logic pin, logic edg);
    logic [EventW-1:0] ev;
    logic [TimeW-1:0]  quiet;
    logic [TimeW-1:0]  held;
    logic [TimeW-1:0]  since;
    click_expect_t     e;
    ev = EV_NONE;
    if (edg) st.debounce_stamp = now;
    quiet = now - st.debounce_stamp;
    if (quiet >= {16'd0, cfg.debounce_ms} && pin != st.pressed) begin
      st.pressed = pin;
      if (pin) begin
        st.press_stamp = now;
        st.long_done = 1'b0;
        st.very_long_done = 1'b0;
      end else if (!st.long_done && !st.very_long_done) begin
        if (st.click_tally != TALLY_MAX) st.click_tally = st.click_tally + 2'd1;
        st.release_stamp = now;
        st.awaiting_more = 1'b1;
      end else begin
        // release after a long hold drops any pending clicks
        st.click_tally = '0;
        st.awaiting_more = 1'b0;
      end
    end
    if (st.pressed) begin
      held = now - st.press_stamp;
      if (!st.very_long_done && held >= {16'd0, cfg.very_long_press_ms}) begin
        ev = EV_VERY_LONG;
        st.very_long_done = 1'b1;
        st.long_done = 1'b1;
      end else if (!st.long_done && held >= {16'd0, cfg.long_press_ms}) begin
        ev = EV_LONG;
        st.long_done = 1'b1;
      end
    end else if (st.awaiting_more) begin
      since = now - st.release_stamp;
      if (since >= {16'd0, cfg.multi_click_window_ms} || st.click_tally == TALLY_MAX) begin
        case (st.click_tally)
          2'd1:      ev = EV_SHORT;
          2'd2:      ev = EV_DOUBLE;
          TALLY_MAX: ev = EV_TRIPLE;
          default:   ev = EV_NONE;
        endcase
        st.click_tally = '0;
        st.awaiting_more = 1'b0;
      end
    end
    e.code = ev;
    e.now = now;
    e.seq = polls;
    expected_events.push_back(e);
    polls++;
  endfunction

  task report(string what);
    // keep the log short on a badly broken block
    if (errors < 25) $display("MISMATCH @%0t: %s", $time, what);
    errors++;
  endtask

  task check_event(logic [EventW-1:0] code);
    click_expect_t e;
    if (expected_events.size() == 0) begin
      report($sformatf("event_code %0d with no poll outstanding", code));
      return;
    end
    e = expected_events.pop_front();
    checked++;
    hits[e.code]++;
    if (code !== e.code)
      report($sformatf("poll %0d (now_ms %0d): event_code %0d, expected %0d",
                       e.seq, e.now, code, e.code));
  endtask
endclass

module tb_button_click_classifier;

  localparam int unsigned CycleLimit = 200000;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [TimeW-1:0]    in_now_ms;
  logic                in_raw_pin;
  logic                in_edge_flag;
  logic                out_valid;
  logic                out_ready;
  logic [EventW-1:0]   out_event_code;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgW-1:0]     cfg_data;

  click_scoreboard  sb;
  logic [TimeW-1:0] now_cursor;
  bit               steady;       // no idling on either side
  int unsigned      cycles = 0;
  int unsigned      settings_run = 1;

  button_click_classifier DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_now_ms(in_now_ms),
    .in_raw_pin(in_raw_pin), .in_edge_flag(in_edge_flag),
    .out_valid(out_valid), .out_ready(out_ready), .out_event_code(out_event_code),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_event(out_event_code);
    out_ready <= steady || ($urandom_range(0, 99) >= 23);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d events outstanding",
               cycles, sb.expected_events.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_poll(logic [TimeW-1:0] now, logic pin, logic edg);
    if (!steady && $urandom_range(0, 99) < 20) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_now_ms <= now;
    in_raw_pin <= pin;
    in_edge_flag <= edg;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_poll(now, pin, edg);
  endtask

  task automatic poll(int unsigned dt, logic pin, logic edg);
    now_cursor = now_cursor + dt;
    send_poll(now_cursor, pin, edg);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_events.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, data);
  endtask

  task automatic configure(logic [CfgW-1:0] deb, logic [CfgW-1:0] lng,
                           logic [CfgW-1:0] vlng, logic [CfgW-1:0] win);
    drain();
    cfg_write(REG_DEBOUNCE, deb);
    cfg_write(REG_LONG, lng);
    cfg_write(REG_VERY_LONG, vlng);
    // an index past the last register must change nothing
    cfg_write(CfgIdxW'($urandom_range(REG_WINDOW + 1, 255)), CfgW'($urandom));
    cfg_write(REG_WINDOW, win);
    cfg_valid <= 1'b0;
    settings_run++;
  endtask

  function automatic int unsigned below(int unsigned x);
    return (x == 0) ? 0 : $urandom_range(0, x - 1);
  endfunction

  function automatic int unsigned beyond(int unsigned x);
    return x + $urandom_range(0, 3);
  endfunction

  // Drive the pin to a level, with optional bounce, until it is adopted.
  task automatic settle(logic level);
    int unsigned deb;
    deb = 32'(sb.cfg.debounce_ms);
    if ($urandom_range(0, 3) == 0) begin
      poll(beyond(deb), level, 1'b0);
      return;
    end
    repeat ($urandom_range(0, 2)) begin
      poll(below(deb), level, 1'b1);
      poll(below(deb), ~level, 1'b1);
    end
    poll(below(deb), level, 1'b1);
    poll(beyond(deb), level, 1'b0);
  endtask

  task automatic hold_for(int unsigned span);
    int unsigned part;
    repeat ($urandom_range(0, 2)) begin
      part = $urandom_range(0, span);
      poll(part, 1'b1, 1'b0);
      span -= part;
    end
    poll(span, 1'b1, 1'b0);
  endtask

  task automatic click(int unsigned span);
    settle(1'b1);
    hold_for(span);
    settle(1'b0);
  endtask

  task automatic burst();
    int unsigned lng;
    int unsigned win;
    int          n;
    lng = 32'(sb.cfg.long_press_ms);
    win = 32'(sb.cfg.multi_click_window_ms);
    n = $urandom_range(1, 4);
    for (int i = 0; i < n; i++) begin
      click(($urandom_range(0, 9) == 0) ? beyond(lng) : below(lng));
      if (i < n - 1) poll(below(win), 1'b0, 1'b0);
    end
    if ($urandom_range(0, 9) < 7) begin
      if ($urandom_range(0, 1)) poll(below(win), 1'b0, 1'b0);
      poll(beyond(win), 1'b0, 1'b0);
    end
  endtask

  task automatic long_hold();
    int unsigned lng;
    int unsigned vlng;
    int unsigned span;
    lng = 32'(sb.cfg.long_press_ms);
    vlng = 32'(sb.cfg.very_long_press_ms);
    case ($urandom_range(0, 3))
      0:       span = beyond(lng);
      1:       span = beyond(vlng);
      2:       span = below(vlng);
      default: span = beyond((lng > vlng) ? lng : vlng) + $urandom_range(0, 5000);
    endcase
    click(span);
  endtask

  task automatic noise();
    repeat ($urandom_range(1, 5)) begin
      case ($urandom_range(0, 3))
        0:       poll($urandom, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        1:       poll($urandom_range(0, 3), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
        default: poll(below(32'(sb.cfg.debounce_ms)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
      endcase
    end
  endtask

  task automatic run_random(int unsigned count);
    int unsigned stop;
    stop = sb.polls + count;
    while (sb.polls < stop) begin
      case ($urandom_range(0, 9))
        0, 1:    noise();
        2, 3, 4: long_hold();
        default: burst();
      endcase
      if ($urandom_range(0, 39) == 0) drain();
    end
  endtask

  initial begin
    int unsigned guard;
    sb = new();
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_now_ms <= '0;
    in_raw_pin <= 1'b0;
    in_edge_flag <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    steady = 1'b0;
    now_cursor = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: bounce, short/double/triple, press inside the window,
    // long then very long, release after a hold, wrap with both thresholds at once
    send_poll(32'd0, 1'b0, 1'b0);
    send_poll(32'd100, 1'b1, 1'b1);
    send_poll(32'd120, 1'b0, 1'b1);
    send_poll(32'd170, 1'b1, 1'b0);
    send_poll(32'd200, 1'b0, 1'b0);
    send_poll(32'd500, 1'b0, 1'b0);
    send_poll(32'd510, 1'b1, 1'b0);
    send_poll(32'd520, 1'b0, 1'b0);
    send_poll(32'd530, 1'b1, 1'b0);
    send_poll(32'd540, 1'b0, 1'b0);
    send_poll(32'd839, 1'b0, 1'b0);
    send_poll(32'd840, 1'b0, 1'b0);
    send_poll(32'd900, 1'b1, 1'b0);
    send_poll(32'd910, 1'b0, 1'b0);
    send_poll(32'd920, 1'b1, 1'b0);
    send_poll(32'd930, 1'b0, 1'b0);
    send_poll(32'd940, 1'b1, 1'b0);
    send_poll(32'd950, 1'b0, 1'b0);
    send_poll(32'd1000, 1'b1, 1'b0);
    send_poll(32'd2000, 1'b1, 1'b0);
    send_poll(32'd4000, 1'b1, 1'b0);
    send_poll(32'd4010, 1'b0, 1'b0);
    send_poll(32'hFFFF_FFFF, 1'b1, 1'b0);
    send_poll(32'h0000_0BB8, 1'b1, 1'b0);
    send_poll(32'h0000_0BC2, 1'b0, 1'b1);
    now_cursor = 32'h0000_0BC2;

    run_random(260);
    configure(16'd3, 16'd40, 16'd90, 16'd25);
    steady = 1'b1;
    run_random(300);
    steady = 1'b0;
    configure(16'd0, 16'd0, 16'd0, 16'd0);
    run_random(260);
    configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    now_cursor = 32'hFFFF_0000;
    run_random(260);
    // long threshold above the very long one
    configure(16'd10, 16'd600, 16'd200, 16'd150);
    now_cursor = $urandom;
    run_random(260);
    configure(CfgW'($urandom), CfgW'($urandom), CfgW'($urandom), CfgW'($urandom));
    run_random(260);
    configure(CfgW'($urandom_range(0, 200)), CfgW'($urandom_range(0, 200)),
              CfgW'($urandom_range(0, 200)), CfgW'($urandom_range(0, 200)));
    run_random(260);

    in_valid <= 1'b0;
    guard = 0;
    while (sb.expected_events.size() != 0 && guard < 2000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
    if (sb.expected_events.size() != 0)
      sb.report($sformatf("%0d events never arrived", sb.expected_events.size()));

    $display("Ran %0d polls under %0d register settings, %0d events checked, %0d mismatches",
             sb.polls, settings_run, sb.checked, sb.errors);
    $display("Events: short %0d, double %0d, triple %0d, long %0d, very long %0d",
             sb.hits[EV_SHORT], sb.hits[EV_DOUBLE], sb.hits[EV_TRIPLE],
             sb.hits[EV_LONG], sb.hits[EV_VERY_LONG]);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- button_click_classifier.f -----
design/bcc_pkg.sv
design/bcc_core.sv
design/button_click_classifier.sv
bench/tb_button_click_classifier.sv
